>>> src/csu_pkg.sv
// ----------------------------------------------------------------------------
// csu_pkg
// Types and constants for the C string literal unescape core.
// ----------------------------------------------------------------------------
package csu_pkg;

  typedef struct packed {
    logic [7:0] char_in;
    logic       last_char;
  } csu_in_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       byte_present;
    logic       end_of_literal;
    logic [1:0] status;
  } csu_out_t;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_BODY = 3'd1,
    MODE_ESC  = 3'd2,
    MODE_OCT  = 3'd3,
    MODE_HEX  = 3'd4,
    MODE_SKIP = 3'd5
  } csu_mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_HEX   = 2'd1,
    ST_UNTERM    = 2'd2
  } csu_status_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_V      = 8'h76;

  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);

  function automatic csu_out_t make_byte(input logic [7:0] b);
    csu_out_t r;
    r.byte_out       = b;
    r.byte_present   = 1'b1;
    r.end_of_literal = 1'b0;
    r.status         = ST_OK;
    return r;
  endfunction

  function automatic csu_out_t make_end(input csu_status_t st);
    csu_out_t r;
    r.byte_out       = 8'd0;
    r.byte_present   = 1'b0;
    r.end_of_literal = 1'b1;
    r.status         = st;
    return r;
  endfunction

endpackage

>>> src/c_string_literal_unescape_core.sv
// ----------------------------------------------------------------------------
// c_string_literal_unescape_core
// Decodes a quoted C string literal, one character per transfer, into bytes.
// ----------------------------------------------------------------------------
//  channel  | ports                         | carries
//  input    | in_valid, in_ready, in_data   | one raw character, last flag
//  result   | out_valid, out_ready, out_data| decoded byte or end status
//
// one character is decoded per cycle; the decode state updates on the same
// edge as the input transfer and results go into a 4-entry result queue.
// a character gives at most two results, so input is taken while the queue
// has at least two free entries; sustained rate is one character per cycle as
// long as the result side drains results as fast as they are produced.
// reset returns the decoder to waiting for the opening character (its value is
// not checked) and empties the queue.
// ----------------------------------------------------------------------------
module c_string_literal_unescape_core
  import csu_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  csu_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output csu_out_t out_data
);

  csu_mode_t  mode_r, mode_nxt;
  logic [8:0] esc_r, esc_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  csu_out_t   oq_r [OQ_DEPTH];
  logic [OQ_AW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [OQ_AW:0]   fill_r, fill_nxt;

  logic       in_xfer, out_xfer;
  logic [7:0] c;
  logic       last;
  logic       is_oct, is_hex, body;
  logic [3:0] hex_d;
  logic [8:0] oct_v;
  logic [7:0] hex_v;
  logic [1:0] cnt_inc;
  logic       pre_vld, main_vld;
  csu_out_t   pre_res, main_res;
  logic       push0, push1;
  csu_out_t   res0, res1;

  assign c    = in_data.char_in;
  assign last = in_data.last_char;

  assign in_ready  = (fill_r <= (OQ_AW+1)'(OQ_DEPTH - 2));
  assign out_valid = (fill_r != '0);
  assign out_data  = oq_r[head_r];
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid && out_ready;

  // character classes
  always_comb begin
    is_oct = (c >= "0") && (c <= "7");
    is_hex = 1'b1;
    hex_d  = 4'd0;
    if ((c >= "0") && (c <= "9")) begin
      hex_d = 4'(c - "0");
    end else if ((c >= "a") && (c <= "f")) begin
      hex_d = 4'(c - "a" + 8'd10);
    end else if ((c >= "A") && (c <= "F")) begin
      hex_d = 4'(c - "A" + 8'd10);
    end else begin
      is_hex = 1'b0;
    end
  end

  assign oct_v   = {esc_r[5:0], c[2:0]};
  assign hex_v   = {esc_r[3:0], hex_d};
  assign cnt_inc = cnt_r + 2'd1;

  // decode
  always_comb begin
    mode_nxt = mode_r;
    esc_nxt  = esc_r;
    cnt_nxt  = cnt_r;
    pre_vld  = 1'b0;
    pre_res  = make_byte(esc_r[7:0]);
    main_vld = 1'b0;
    main_res = make_byte(c);
    body     = 1'b0;
    case (mode_r)
      MODE_BODY: begin
        body = 1'b1;
      end
      MODE_SKIP: begin
        if (last) begin
          mode_nxt = MODE_IDLE;
        end
      end
      MODE_OCT: begin
        if (is_oct) begin
          if (last) begin
            main_vld = 1'b1;
            main_res = make_end(ST_UNTERM);
            mode_nxt = MODE_IDLE;
            esc_nxt  = '0;
            cnt_nxt  = '0;
          end else if (cnt_inc == 2'd3) begin
            main_vld = 1'b1;
            main_res = make_byte(oct_v[7:0]);
            mode_nxt = MODE_BODY;
            esc_nxt  = '0;
            cnt_nxt  = '0;
          end else begin
            esc_nxt = oct_v;
            cnt_nxt = cnt_inc;
          end
        end else begin
          pre_vld  = 1'b1;
          mode_nxt = MODE_BODY;
          esc_nxt  = '0;
          cnt_nxt  = '0;
          body     = 1'b1;
        end
      end
      MODE_HEX: begin
        if (is_hex) begin
          if (last) begin
            main_vld = 1'b1;
            main_res = make_end(ST_UNTERM);
            mode_nxt = MODE_IDLE;
            esc_nxt  = '0;
            cnt_nxt  = '0;
          end else if (cnt_inc >= 2'd2) begin
            main_vld = 1'b1;
            main_res = make_byte(hex_v);
            mode_nxt = MODE_BODY;
            esc_nxt  = '0;
            cnt_nxt  = '0;
          end else begin
            esc_nxt = {1'b0, hex_v};
            cnt_nxt = cnt_inc;
          end
        end else if (cnt_r == 2'd0) begin
          main_vld = 1'b1;
          main_res = make_end(ST_BAD_HEX);
          mode_nxt = last ? MODE_IDLE : MODE_SKIP;
          esc_nxt  = '0;
          cnt_nxt  = '0;
        end else begin
          pre_vld  = 1'b1;
          mode_nxt = MODE_BODY;
          esc_nxt  = '0;
          cnt_nxt  = '0;
          body     = 1'b1;
        end
      end
      MODE_ESC: begin
        if (last) begin
          main_vld = 1'b1;
          main_res = make_end(ST_UNTERM);
          mode_nxt = MODE_IDLE;
          esc_nxt  = '0;
          cnt_nxt  = '0;
        end else begin
          mode_nxt = MODE_BODY;
          main_vld = 1'b1;
          case (c)
            CH_B: main_res = make_byte(8'd8);
            CH_F: main_res = make_byte(8'd12);
            CH_N: main_res = make_byte(8'd10);
            CH_R: main_res = make_byte(8'd13);
            CH_T: main_res = make_byte(8'd9);
            CH_A: main_res = make_byte(8'd7);
            CH_V: main_res = make_byte(8'd11);
            CH_X: begin
              main_vld = 1'b0;
              mode_nxt = MODE_HEX;
              esc_nxt  = '0;
              cnt_nxt  = '0;
            end
            default: begin
              if (is_oct) begin
                main_vld = 1'b0;
                mode_nxt = MODE_OCT;
                esc_nxt  = {6'd0, c[2:0]};
                cnt_nxt  = 2'd1;
              end
            end
          endcase
        end
      end
      default: begin
        if (last) begin
          main_vld = 1'b1;
          main_res = make_end(ST_UNTERM);
          mode_nxt = MODE_IDLE;
        end else begin
          mode_nxt = MODE_BODY;
        end
        esc_nxt = '0;
        cnt_nxt = '0;
      end
    endcase

    // plain body character
    if (body) begin
      if (last) begin
        main_vld = 1'b1;
        main_res = make_end((c == CH_QUOTE) ? ST_OK : ST_UNTERM);
        mode_nxt = MODE_IDLE;
        esc_nxt  = '0;
        cnt_nxt  = '0;
      end else if (c == CH_BSLASH) begin
        mode_nxt = MODE_ESC;
      end else begin
        main_vld = 1'b1;
        main_res = make_byte(c);
      end
    end
  end

  // order results into queue slots
  always_comb begin
    push0 = in_xfer && (pre_vld || main_vld);
    push1 = in_xfer && pre_vld && main_vld;
    res0  = pre_vld ? pre_res : main_res;
    res1  = main_res;
  end

  always_comb begin
    tail_nxt = tail_r;
    head_nxt = head_r;
    fill_nxt = fill_r;
    if (push0) begin
      tail_nxt = push1 ? tail_r + OQ_AW'(2) : tail_r + OQ_AW'(1);
    end
    if (out_xfer) begin
      head_nxt = head_r + OQ_AW'(1);
    end
    fill_nxt = fill_r + (OQ_AW+1)'(push0) + (OQ_AW+1)'(push1) - (OQ_AW+1)'(out_xfer);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      esc_r  <= '0;
      cnt_r  <= '0;
      head_r <= '0;
      tail_r <= '0;
      fill_r <= '0;
    end else begin
      if (in_xfer) begin
        mode_r <= mode_nxt;
        esc_r  <= esc_nxt;
        cnt_r  <= cnt_nxt;
      end
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      fill_r <= fill_nxt;
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (push0) begin
      oq_r[tail_r] <= res0;
    end
    if (push1) begin
      oq_r[tail_r + OQ_AW'(1)] <= res1;
    end
  end

endmodule
